FILE: src/lrde_pkg.sv
`timescale 1ns / 1ps

package lrde_pkg;

  localparam int IDX_BITS = 5;     // sensor_index width, also the step counter width
  localparam int SUM_W    = 20;    // signed width of the vector sums
  localparam int SCALE_SH = 16;    // sums are scaled by 2^16 before the cordic
  localparam int CW       = SUM_W + SCALE_SH + 2;
  localparam int ZW       = 27;    // angle accumulator, degrees * 2^16
  localparam int FRAC_SH  = 12;    // degrees * 2^16 -> degrees * 16

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_THRESH = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [9:0]           THRESH_INIT = 10'd1023;
  localparam logic [IDX_BITS-1:0]  COS_OFS     = 5'd8;
  localparam logic [4:0]           SEEN_CAP    = 5'd31;
  localparam logic signed [ZW-1:0] Z90         = 27'sd5898240;
  localparam logic signed [ZW-1:0] ROUND_HALF  = 27'sd2048;
  localparam logic signed [ZW-1:0] DIR_HALF    = 27'sd2880;
  localparam logic signed [ZW-1:0] DIR_MAX     = 27'sd5760;

  typedef struct packed {
    logic [1:0] operation;
    logic [4:0] sensor_index;
    logic [9:0] value;
    logic       frame_end;
  } sample_t;

  typedef struct packed {
    logic        line_seen;
    logic [12:0] direction;
    logic [4:0]  seen_total;
  } result_t;

  typedef struct packed {
    logic item;
    logic scan_step;
    logic prerot;
    logic iter;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic frame_trig;
    logic scan_last;
    logic iter_last;
    logic any_over;
    logic out_busy;
  } status_t;

  // sin over the first quarter, steps of 11.25 degrees, Q1.14
  function automatic logic signed [15:0] quarter_sin(input logic [3:0] m);
    case (m)
      4'd0: return 16'sd0;
      4'd1: return 16'sd3196;
      4'd2: return 16'sd6270;
      4'd3: return 16'sd9102;
      4'd4: return 16'sd11585;
      4'd5: return 16'sd13623;
      4'd6: return 16'sd15137;
      4'd7: return 16'sd16069;
      4'd8: return 16'sd16384;
      default: return 16'sd0;
    endcase
  endfunction

  function automatic logic signed [15:0] sin_step(input logic [IDX_BITS-1:0] k);
    if (k <= 5'd8) begin
      return quarter_sin(k[3:0]);
    end else if (k <= 5'd16) begin
      return quarter_sin(4'(5'd16 - k));
    end else if (k <= 5'd24) begin
      return -quarter_sin(4'(k - 5'd16));
    end else begin
      return -quarter_sin(4'(5'd0 - k));
    end
  endfunction

  // atan(2^-i) in degrees * 2^16
  function automatic logic signed [ZW-1:0] atan_q16(input logic [IDX_BITS-1:0] i);
    case (i)
      5'd0:  return 27'sd2949120;
      5'd1:  return 27'sd1740967;
      5'd2:  return 27'sd919879;
      5'd3:  return 27'sd466945;
      5'd4:  return 27'sd234379;
      5'd5:  return 27'sd117304;
      5'd6:  return 27'sd58666;
      5'd7:  return 27'sd29335;
      5'd8:  return 27'sd14668;
      5'd9:  return 27'sd7334;
      5'd10: return 27'sd3667;
      5'd11: return 27'sd1833;
      5'd12: return 27'sd917;
      5'd13: return 27'sd458;
      5'd14: return 27'sd229;
      5'd15: return 27'sd115;
      5'd16: return 27'sd57;
      5'd17: return 27'sd29;
      5'd18: return 27'sd14;
      5'd19: return 27'sd7;
      5'd20: return 27'sd4;
      5'd21: return 27'sd2;
      5'd22: return 27'sd1;
      default: return 27'sd0;
    endcase
  endfunction

endpackage

FILE: src/lrde_stream_if.sv
`timescale 1ns / 1ps

interface lrde_stream_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/lrde_ctrl.sv
`timescale 1ns / 1ps

module lrde_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lrde_pkg::status_t sts,
  output lrde_pkg::cmd_t    cmd
);
  import lrde_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ROT  = 3'd2;
  localparam logic [2:0] S_ITER = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.item = 1'b1;
          if (sts.frame_trig) state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_next = sts.any_over ? S_ROT : S_EMIT;
      end
      S_ROT: begin
        cmd.prerot = 1'b1;
        state_next = S_ITER;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (sts.iter_last) state_next = S_EMIT;
      end
      S_EMIT: begin
        // wait until the output register is free
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/lrde_dp.sv
`timescale 1ns / 1ps

module lrde_dp #(
  parameter int NUM_SENSORS  = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  lrde_pkg::sample_t in_data,
  input  logic              out_ready,
  input  lrde_pkg::cmd_t    cmd,
  output lrde_pkg::status_t sts,
  output logic              out_valid,
  output lrde_pkg::result_t out_data
);
  import lrde_pkg::*;

  localparam int IDX_W = $clog2(NUM_SENSORS);
  localparam logic [IDX_BITS:0]   RING_SIZE = (IDX_BITS + 1)'(NUM_SENSORS);
  localparam logic [IDX_BITS-1:0] SCAN_LAST = IDX_BITS'(NUM_SENSORS - 1);
  localparam logic [IDX_BITS-1:0] ITER_LAST = IDX_BITS'(CORDIC_STEPS - 1);

  logic [9:0]             thr [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] over;
  logic [NUM_SENSORS-1:0] seen;
  logic [4:0]             seen_count;
  logic [IDX_BITS-1:0]    cnt;
  logic signed [SUM_W-1:0] xs, ys;
  logic signed [CW-1:0]    cx, cy;
  logic signed [ZW-1:0]    cz;
  logic                    zero_vec;

  logic                    in_ring;
  logic [IDX_W-1:0]        widx;
  logic [IDX_W-1:0]        si;
  logic                    add_bit;
  logic                    take;
  logic signed [15:0]      sin_x, sin_y;
  logic signed [CW-1:0]    px, py, dx, dy;
  logic signed [ZW-1:0]    at;
  logic signed [ZW-1:0]    zf, za, zd, zabs;
  logic [12:0]             dir;

  assign in_ring = {1'b0, in_data.sensor_index} < RING_SIZE;
  assign widx    = in_data.sensor_index[IDX_W-1:0];

  // ring scan: seen update in index order, then add the sensor vector
  assign si      = cnt[IDX_W-1:0];
  assign add_bit = over[si] && !seen[si] && (seen_count != SEEN_CAP);
  assign take    = seen[si] || add_bit;
  assign sin_x   = sin_step(cnt);
  assign sin_y   = sin_step(cnt + COS_OFS);

  assign px = CW'(xs) <<< SCALE_SH;
  assign py = CW'(ys) <<< SCALE_SH;
  assign dx = cy >>> cnt;
  assign dy = cx >>> cnt;
  assign at = atan_q16(cnt);

  // round to 1/16 degree, fold about 180 degrees, saturate
  assign zf   = zero_vec ? '0 : cz;
  assign za   = (zf + ROUND_HALF) >>> FRAC_SH;
  assign zd   = za - DIR_HALF;
  assign zabs = (zd < 0) ? -zd : zd;
  assign dir  = (zabs > DIR_MAX) ? DIR_MAX[12:0] : zabs[12:0];

  assign sts.frame_trig = (in_data.operation == OP_SAMPLE) && in_data.frame_end;
  assign sts.scan_last  = (cnt == SCAN_LAST);
  assign sts.iter_last  = (cnt == ITER_LAST);
  assign sts.any_over   = |over;
  assign sts.out_busy   = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_SENSORS; k++) thr[k] <= THRESH_INIT;
    end else if (cmd.item && in_data.operation == OP_THRESH && in_ring) begin
      thr[widx] <= in_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      over       <= '0;
      seen       <= '0;
      seen_count <= '0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.item) begin
        cnt <= '0;
        if (in_data.operation == OP_CLEAR) begin
          over       <= '0;
          seen       <= '0;
          seen_count <= '0;
        end else if (in_data.operation == OP_SAMPLE && in_ring &&
                     in_data.value > thr[widx]) begin
          over[widx] <= 1'b1;
        end
      end else if (cmd.scan_step) begin
        cnt <= cnt + 1'b1;
        if (add_bit) begin
          seen[si]   <= 1'b1;
          seen_count <= seen_count + 1'b1;
        end
      end else if (cmd.prerot) begin
        cnt <= '0;
      end else if (cmd.iter) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item) begin
      xs <= '0;
      ys <= '0;
    end else if (cmd.scan_step && take) begin
      xs <= xs - SUM_W'(sin_x);
      ys <= ys + SUM_W'(sin_y);
    end
    if (cmd.prerot) begin
      zero_vec <= (xs == '0) && (ys == '0);
      // bring the vector into the right half plane
      if (px < 0) begin
        if (py >= 0) begin
          cx <= py;
          cy <= -px;
          cz <= Z90;
        end else begin
          cx <= -py;
          cy <= px;
          cz <= -Z90;
        end
      end else begin
        cx <= px;
        cy <= py;
        cz <= '0;
      end
    end else if (cmd.iter) begin
      if (cy > 0) begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + at;
      end else begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - at;
      end
    end
    if (cmd.emit) begin
      out_data.line_seen  <= sts.any_over;
      out_data.direction  <= sts.any_over ? dir : '0;
      out_data.seen_total <= seen_count;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && !out_ready))
    else $error("result loaded while output register still held");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("output valid without a result load");

  a_scan_in_ring: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> cnt <= SCAN_LAST)
    else $error("scan counter ran past the ring");

  a_no_line_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.line_seen |-> out_data.direction == '0)
    else $error("direction nonzero with no line seen");

endmodule

FILE: src/line_ring_direction_estimator.sv
`timescale 1ns / 1ps
// threshold write, clear, plain sample: taken in idle, next item the cycle after
// frame end: ring scan, then pre-rotation and cordic loop, then the result load
//   (scan straight to load when no sensor is over); the load waits while output is held
// no new item is accepted until the frame's result is loaded
// reset: synchronous; thresholds go to 1023, over/seen masks and seen count clear
module line_ring_direction_estimator #(
  parameter int NUM_SENSORS  = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  lrde_stream_if.sink   sample,
  lrde_stream_if.source result
);
  import lrde_pkg::*;

  cmd_t    cmd;
  status_t sts;
  logic    in_ready;
  logic    out_valid;
  result_t out_data;

  assign sample.ready = in_ready;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  lrde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lrde_dp #(
    .NUM_SENSORS  (NUM_SENSORS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (sample.data),
    .out_ready (result.ready),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lrde_pkg::*;

  localparam int RING       = 32;
  localparam int CSTEPS     = 16;
  localparam int QUIET_MAX  = 4000;
  localparam int ITEM_GOAL  = 1700;
  localparam int SETTLE     = 64;
  localparam int PRINT_CAP  = 100;
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic clk;
  logic rst;

  lrde_stream_if #(.data_t(sample_t)) sample_ch ();
  lrde_stream_if #(.data_t(result_t)) result_ch ();

  line_ring_direction_estimator dut (
    .clk(clk),
    .rst(rst),
    .sample(sample_ch),
    .result(result_ch)
  );

  always #5 clk = ~clk;

  // Q1.14 sine over one quarter turn, 11.25 degree steps
  int qsin [0:8] = '{0, 3196, 6270, 9102, 11585, 13623, 15137, 16069, 16384};
  // atan(2^-i) in degrees * 2^16
  longint atan_deg [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // predicted block state
  logic [9:0]  thresh [0:31];
  logic [31:0] over_bits;
  logic [31:0] seen_bits;
  int          seen_n;

  sample_t sample_backlog [$];
  result_t due_results [$];
  int      counted_items;
  int      mismatch_count;
  int      send_idle_pct;
  int      stall_pct;
  int      quiet_cycles;

  function automatic int ring_sin(input int k);
    int m;
    m = k & 31;
    if (m <= 8) return qsin[m];
    if (m <= 16) return qsin[16 - m];
    if (m <= 24) return -qsin[m - 16];
    return -qsin[32 - m];
  endfunction

  // vectoring cordic, angle in degrees * 2^16
  function automatic longint heading_q16(input longint ys, input longint xs);
    longint x, y, z, t, dx, dy;
    int     steps, i;
    z = 0;
    steps = (CSTEPS > 24) ? 24 : CSTEPS;
    if (xs == 0 && ys == 0) return 0;
    x = xs * 65536;
    y = ys * 65536;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; z = -90 * 65536;
      end
    end
    for (i = 0; i < steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_deg[i];
      end else begin
        x -= dx; y += dy; z -= atan_deg[i];
      end
    end
    return z;
  endfunction

  // updates the predicted state; returns 1 when the transaction yields a result
  function automatic bit ring_estimate(input sample_t it, output result_t r);
    logic [31:0] over;
    longint      xs, ys, ang, d;
    int          i;
    r = '0;
    xs = 0;
    ys = 0;
    case (it.operation)
      OP_THRESH: begin
        if (it.sensor_index < RING) thresh[it.sensor_index] = it.value;
        return 0;
      end
      OP_CLEAR: begin
        over_bits = '0;
        seen_bits = '0;
        seen_n = 0;
        return 0;
      end
      OP_SAMPLE: ;
      default: return 0;
    endcase
    if (it.sensor_index < RING && it.value > thresh[it.sensor_index])
      over_bits[it.sensor_index] = 1'b1;
    if (!it.frame_end) return 0;
    over = over_bits & 32'((64'd1 << RING) - 1);
    for (i = 0; i < RING; i++) begin
      if (over[i] && seen_n <= 30 && !seen_bits[i]) begin
        seen_bits[i] = 1'b1;
        seen_n++;
      end
    end
    r.line_seen = (over != 0);
    r.seen_total = 5'(seen_n);
    if (over == 0) return 1;
    for (i = 0; i < RING; i++) begin
      if (seen_bits[i]) begin
        xs -= ring_sin(i);
        ys += ring_sin(i + 8);
      end
    end
    ang = (heading_q16(ys, xs) + 2048) >>> 12;
    d = ang - 2880;
    if (d < 0) d = -d;
    if (d > 5760) d = 5760;
    r.direction = 13'(d);
    return 1;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic put(input logic [1:0] op, input int idx, input int val, input bit fe);
    sample_t it;
    it.operation = op;
    it.sensor_index = 5'(idx);
    it.value = 10'(val);
    it.frame_end = fe;
    sample_backlog.push_back(it);
    if (op != OP_SPARE) counted_items++;
  endtask

  task automatic put_noise();
    case ($urandom_range(3))
      0: put(OP_SPARE, $urandom_range(31), $urandom_range(1023), 1'($urandom_range(1)));
      1: put(OP_THRESH, $urandom_range(31), $urandom_range(1023), 1'b1);
      2: put(OP_CLEAR, $urandom_range(31), $urandom_range(1023), 1'b1);
      default: put(OP_SAMPLE, $urandom_range(31), $urandom_range(1023), 1'b1);
    endcase
  endtask

  // one episode: clear, retune some or all thresholds, then a few frames
  task automatic add_episode();
    int kind, frames, len, f, s, k;
    kind = $urandom_range(99);
    put(OP_CLEAR, $urandom_range(31), $urandom_range(1023), 1'($urandom_range(1)));
    if (kind < 8) begin
      // whole ring over, drives the seen count into its cap
      for (k = 0; k < 32; k++)
        put(OP_THRESH, k, $urandom_range(100), 1'($urandom_range(1)));
      for (k = 0; k < 32; k++)
        put(OP_SAMPLE, k, $urandom_range(1023, 200), (k % 8) == 7);
      put(OP_SAMPLE, $urandom_range(31), $urandom_range(1023), 1'b1);
    end else begin
      len = $urandom_range(6);
      for (k = 0; k < len; k++)
        put(OP_THRESH, $urandom_range(31), $urandom_range(1023), 1'($urandom_range(1)));
      frames = $urandom_range(5, 1);
      for (f = 0; f < frames; f++) begin
        len = $urandom_range(6, 1);
        for (s = 0; s < len; s++)
          put(OP_SAMPLE, $urandom_range(31), $urandom_range(1023), s == len - 1);
        if ($urandom_range(99) < 15) put_noise();
      end
    end
    if ($urandom_range(99) < 20) put_noise();
  endtask

  // driver
  always @(posedge clk) begin
    result_t r;
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        if (ring_estimate(sample_ch.data, r)) due_results.push_back(r);
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_ch.data <= sample_backlog.pop_front();
          sample_ch.valid <= 1'b1;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (due_results.size() == 0) begin
        flag_mismatch("result transaction with none pending", int'(result_ch.data), 0);
      end else begin
        want = due_results.pop_front();
        if (result_ch.data.line_seen !== want.line_seen)
          flag_mismatch("line_seen", int'(result_ch.data.line_seen), int'(want.line_seen));
        if (result_ch.data.direction !== want.direction)
          flag_mismatch("direction", int'(result_ch.data.direction), int'(want.direction));
        if (result_ch.data.seen_total !== want.seen_total)
          flag_mismatch("seen_total", int'(result_ch.data.seen_total),
                        int'(want.seen_total));
      end
    end
  end

  // watchdog on stretches with no transaction on either side
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("line_ring_direction_estimator: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int ph, k;
    clk = 1'b0;
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.data = '0;
    result_ch.ready = 1'b0;
    quiet_cycles = 0;
    mismatch_count = 0;
    counted_items = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    for (k = 0; k < 32; k++) thresh[k] = THRESH_INIT;
    over_bits = '0;
    seen_bits = '0;
    seen_n = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: threshold extremes, strict compare, cancelling sums, ignored frame ends
    put(OP_SAMPLE, 0, 1023, 1'b1);
    put(OP_SAMPLE, 31, 0, 1'b0);
    put(OP_THRESH, 0, 0, 1'b1);
    put(OP_SAMPLE, 0, 0, 1'b1);
    put(OP_SAMPLE, 0, 1, 1'b1);
    put(OP_THRESH, 16, 1022, 1'b0);
    put(OP_SAMPLE, 16, 1023, 1'b1);
    put(OP_CLEAR, 31, 1023, 1'b1);
    put(OP_SPARE, 31, 1023, 1'b1);
    put(OP_SAMPLE, 16, 1023, 1'b1);
    put(OP_THRESH, 31, 512, 1'b0);
    put(OP_SAMPLE, 31, 512, 1'b0);
    put(OP_SAMPLE, 31, 513, 1'b1);
    put(OP_THRESH, 8, 0, 1'b0);
    put(OP_SAMPLE, 8, 1023, 1'b1);
    put(OP_CLEAR, 0, 0, 1'b0);
    put(OP_THRESH, 24, 0, 1'b0);
    put(OP_SAMPLE, 24, 1000, 1'b1);
    put(OP_THRESH, 20, 341, 1'b0);
    put(OP_SAMPLE, 20, 682, 1'b1);
    put(OP_SAMPLE, 5, 700, 1'b0);
    put(OP_SPARE, 0, 0, 1'b0);
    put(OP_CLEAR, 21, 682, 1'b1);
    put(OP_SAMPLE, 24, 1023, 1'b1);

    for (ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 68; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 68; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      while (counted_items < (ph + 1) * ITEM_GOAL / 4) add_episode();
      while (sample_backlog.size() != 0) @(posedge clk);
    end

    while (sample_backlog.size() != 0 || sample_ch.valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("line_ring_direction_estimator: match");
    end else begin
      $display("line_ring_direction_estimator: mismatch");
    end
    $finish;
  end

endmodule

FILE: line_ring_direction_estimator.f
src/lrde_pkg.sv
src/lrde_stream_if.sv
src/lrde_ctrl.sv
src/lrde_dp.sv
src/line_ring_direction_estimator.sv
bench/testbench.sv
